[hdl/pta_pkg.sv]
`timescale 1ns / 1ps

package pta_pkg;

  // Widths of the configuration registers and payload fields.
  localparam int IMG_CFG_W = 13;
  localparam int DSP_CFG_W = 10;
  localparam int STEP_W    = 29;
  localparam int CFG_W     = 29;
  localparam int CFG_IDX_W = 3;
  localparam int COLOR_W   = 8;
  localparam int CHAR_W    = 7;
  localparam int SUM_W     = 10;

  // Register indexes of the configuration channel.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_STEP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STEP       = 3'd5;

  // Register values after reset.
  localparam logic [IMG_CFG_W-1:0] IMAGE_WIDTH_RST    = 13'd640;
  localparam logic [IMG_CFG_W-1:0] IMAGE_HEIGHT_RST   = 13'd480;
  localparam logic [DSP_CFG_W-1:0] DISPLAY_WIDTH_RST  = 10'd80;
  localparam logic [DSP_CFG_W-1:0] DISPLAY_HEIGHT_RST = 10'd24;
  localparam logic [STEP_W-1:0]    COLUMN_STEP_RST    = 29'd524288;
  localparam logic [STEP_W-1:0]    ROW_STEP_RST       = 29'd1310720;

  // Brightness levels: the channel sum divided by LEVEL_STEP, 0 to LEVEL_MAX.
  localparam int LEVEL_STEP = 76;
  localparam int LEVEL_MAX  = 10;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 7'h0A;

  // One queue entry: up to a glyph and a newline caused by one pixel.
  typedef struct packed {
    logic              glyph_valid;
    logic [CHAR_W-1:0] glyph;
    logic              newline_valid;
    logic              newline_last;
  } entry_t;

  // Glyph for a brightness level, dark to light.
  function automatic logic [CHAR_W-1:0] glyph_code(input logic [3:0] level);
    logic [CHAR_W-1:0] code;
    case (level)
      4'd0:    code = 7'h40;  // '@'
      4'd1:    code = 7'h25;  // '%'
      4'd2:    code = 7'h23;  // '#'
      4'd3:    code = 7'h26;  // '&'
      4'd4:    code = 7'h2B;  // '+'
      4'd5:    code = 7'h3D;  // '='
      4'd6:    code = 7'h5E;  // '^'
      4'd7:    code = 7'h2D;  // '-'
      4'd8:    code = 7'h3A;  // ':'
      4'd9:    code = 7'h2E;  // '.'
      default: code = 7'h20;  // ' '
    endcase
    return code;
  endfunction

endpackage

[hdl/pta_pixel_if.sv]
`timescale 1ns / 1ps

interface pta_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [pta_pkg::COLOR_W-1:0] red;
  logic [pta_pkg::COLOR_W-1:0] green;
  logic [pta_pkg::COLOR_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

[hdl/pta_char_if.sv]
`timescale 1ns / 1ps

interface pta_char_if;
  logic                       valid;
  logic                       ready;
  logic [pta_pkg::CHAR_W-1:0] character;
  logic                       frame_last;

  modport source (output valid, character, frame_last, input ready);
  modport sink (input valid, character, frame_last, output ready);
endinterface

[hdl/pta_cfg_if.sv]
`timescale 1ns / 1ps

interface pta_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pta_pkg::CFG_IDX_W-1:0] index;
  logic [pta_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/pta_front.sv]
`timescale 1ns / 1ps

module pta_front #(
  parameter int MAX_IMAGE_DIM   = 4096,
  parameter int MAX_DISPLAY_DIM = 512,
  parameter int FRAC_BITS       = 16
) (
  input  logic             clk,
  input  logic             rst,
  pta_pixel_if.sink        pixel,
  pta_cfg_if.sink          cfg,
  input  logic             queue_full,
  output logic             push,
  output pta_pkg::entry_t  push_entry
);

  localparam int COL_W     = $clog2(MAX_IMAGE_DIM);
  localparam int ACC_W     = COL_W + FRAC_BITS;
  localparam int DCNT_W    = $clog2(MAX_DISPLAY_DIM) + 1;
  localparam int IMG_CMP_W = (COL_W + 1 > pta_pkg::IMG_CFG_W) ? COL_W + 1 : pta_pkg::IMG_CFG_W;
  localparam int DSP_CMP_W = (DCNT_W > pta_pkg::DSP_CFG_W) ? DCNT_W : pta_pkg::DSP_CFG_W;
  localparam int ADD_W     = ((ACC_W > pta_pkg::STEP_W) ? ACC_W : pta_pkg::STEP_W) + 1;

  // Configuration registers.
  logic [pta_pkg::IMG_CFG_W-1:0] image_width;
  logic [pta_pkg::IMG_CFG_W-1:0] image_height;
  logic [pta_pkg::DSP_CFG_W-1:0] display_width;
  logic [pta_pkg::DSP_CFG_W-1:0] display_height;
  logic [pta_pkg::STEP_W-1:0]    column_step;
  logic [pta_pkg::STEP_W-1:0]    row_step;

  // Raster and sampling state.
  logic [COL_W-1:0]  source_column, source_column_next;
  logic [COL_W-1:0]  source_row, source_row_next;
  logic [ACC_W-1:0]  column_accumulator, column_accumulator_next;
  logic [ACC_W-1:0]  row_accumulator, row_accumulator_next;
  logic [DCNT_W-1:0] emitted_columns, emitted_columns_next;
  logic [DCNT_W-1:0] emitted_rows, emitted_rows_next;

  logic [IMG_CMP_W-1:0]       iw, ih;
  logic [DSP_CMP_W-1:0]       dw, dh;
  logic                       accept;
  logic                       last_col, last_row, row_sel, pick, closed, newline;
  logic [pta_pkg::SUM_W-1:0]  sum;
  logic [3:0]                 level;

  // Saturating accumulator step; a step below one is taken as one.
  function automatic logic [ACC_W-1:0] acc_add(input logic [ACC_W-1:0] acc,
                                               input logic [pta_pkg::STEP_W-1:0] step);
    logic [ADD_W-1:0] one;
    logic [ADD_W-1:0] s;
    logic [ADD_W-1:0] t;
    logic [ADD_W-1:0] acc_max;
    one     = ADD_W'(1) << FRAC_BITS;
    acc_max = (ADD_W'(1) << ACC_W) - ADD_W'(1);
    s       = (ADD_W'(step) < one) ? one : ADD_W'(step);
    t       = ADD_W'(acc) + s;
    return (t > acc_max) ? {ACC_W{1'b1}} : t[ACC_W-1:0];
  endfunction

  assign cfg.ready   = 1'b1;
  assign pixel.ready = !queue_full;
  assign accept      = pixel.valid && !queue_full;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= pta_pkg::IMAGE_WIDTH_RST;
      image_height   <= pta_pkg::IMAGE_HEIGHT_RST;
      display_width  <= pta_pkg::DISPLAY_WIDTH_RST;
      display_height <= pta_pkg::DISPLAY_HEIGHT_RST;
      column_step    <= pta_pkg::COLUMN_STEP_RST;
      row_step       <= pta_pkg::ROW_STEP_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        pta_pkg::CFG_IMAGE_WIDTH:    image_width    <= cfg.data[pta_pkg::IMG_CFG_W-1:0];
        pta_pkg::CFG_IMAGE_HEIGHT:   image_height   <= cfg.data[pta_pkg::IMG_CFG_W-1:0];
        pta_pkg::CFG_DISPLAY_WIDTH:  display_width  <= cfg.data[pta_pkg::DSP_CFG_W-1:0];
        pta_pkg::CFG_DISPLAY_HEIGHT: display_height <= cfg.data[pta_pkg::DSP_CFG_W-1:0];
        pta_pkg::CFG_COLUMN_STEP:    column_step    <= cfg.data[pta_pkg::STEP_W-1:0];
        pta_pkg::CFG_ROW_STEP:       row_step       <= cfg.data[pta_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Dimensions clamped to their legal ranges.
  always_comb begin
    iw = IMG_CMP_W'(image_width);
    ih = IMG_CMP_W'(image_height);
    dw = DSP_CMP_W'(display_width);
    dh = DSP_CMP_W'(display_height);
    if (iw == '0) iw = IMG_CMP_W'(1);
    else if (iw > IMG_CMP_W'(MAX_IMAGE_DIM)) iw = IMG_CMP_W'(MAX_IMAGE_DIM);
    if (ih == '0) ih = IMG_CMP_W'(1);
    else if (ih > IMG_CMP_W'(MAX_IMAGE_DIM)) ih = IMG_CMP_W'(MAX_IMAGE_DIM);
    if (dw == '0) dw = DSP_CMP_W'(1);
    else if (dw > DSP_CMP_W'(MAX_DISPLAY_DIM)) dw = DSP_CMP_W'(MAX_DISPLAY_DIM);
    if (dh == '0) dh = DSP_CMP_W'(1);
    else if (dh > DSP_CMP_W'(MAX_DISPLAY_DIM)) dh = DSP_CMP_W'(MAX_DISPLAY_DIM);
  end

  // Brightness level by comparing the sum against each level threshold.
  always_comb begin
    sum = pta_pkg::SUM_W'(pixel.red) + pta_pkg::SUM_W'(pixel.green)
        + pta_pkg::SUM_W'(pixel.blue);
    level = 4'd0;
    for (int k = 1; k <= pta_pkg::LEVEL_MAX; k++) begin
      if (sum >= pta_pkg::SUM_W'(k * pta_pkg::LEVEL_STEP)) level = 4'(k);
    end
  end

  // Sampling decision for the pixel at the port.
  always_comb begin
    last_col = (IMG_CMP_W'(source_column) + IMG_CMP_W'(1)) >= iw;
    last_row = (IMG_CMP_W'(source_row) + IMG_CMP_W'(1)) >= ih;
    row_sel  = (DSP_CMP_W'(emitted_rows) < dh)
            && (row_accumulator[ACC_W-1:FRAC_BITS] == source_row);
    pick     = row_sel && (DSP_CMP_W'(emitted_columns) < dw)
            && (column_accumulator[ACC_W-1:FRAC_BITS] == source_column);
    closed   = pick && ((DSP_CMP_W'(emitted_columns) + DSP_CMP_W'(1)) >= dw);
    newline  = row_sel && (closed || last_col);

    push_entry.glyph_valid   = pick;
    push_entry.glyph         = pta_pkg::glyph_code(level);
    push_entry.newline_valid = newline;
    push_entry.newline_last  = (DSP_CMP_W'(emitted_rows) + DSP_CMP_W'(1)) == dh;
    push                     = accept && (pick || newline);
  end

  // Next raster and sampling state.
  always_comb begin
    source_column_next      = source_column;
    source_row_next         = source_row;
    column_accumulator_next = column_accumulator;
    row_accumulator_next    = row_accumulator;
    emitted_columns_next    = emitted_columns;
    emitted_rows_next       = emitted_rows;
    if (pick) begin
      column_accumulator_next = acc_add(column_accumulator, column_step);
      emitted_columns_next    = emitted_columns + DCNT_W'(1);
    end
    if (newline) begin
      emitted_rows_next       = emitted_rows + DCNT_W'(1);
      row_accumulator_next    = acc_add(row_accumulator, row_step);
      column_accumulator_next = '0;
      emitted_columns_next    = '0;
    end
    if (last_col) begin
      source_column_next = '0;
      if (last_row) begin
        source_row_next         = '0;
        column_accumulator_next = '0;
        row_accumulator_next    = '0;
        emitted_columns_next    = '0;
        emitted_rows_next       = '0;
      end else begin
        source_row_next = source_row + COL_W'(1);
      end
    end else begin
      source_column_next = source_column + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_column      <= '0;
      source_row         <= '0;
      column_accumulator <= '0;
      row_accumulator    <= '0;
      emitted_columns    <= '0;
      emitted_rows       <= '0;
    end else if (accept) begin
      source_column      <= source_column_next;
      source_row         <= source_row_next;
      column_accumulator <= column_accumulator_next;
      row_accumulator    <= row_accumulator_next;
      emitted_columns    <= emitted_columns_next;
      emitted_rows       <= emitted_rows_next;
    end
  end

endmodule

[hdl/pta_queue.sv]
`timescale 1ns / 1ps

module pta_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pta_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output pta_pkg::entry_t head
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  pta_pkg::entry_t  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push, do_pop;

  assign full       = count == (PTR_W + 1)'(DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + PTR_W'(1);
      if (do_push && !do_pop) count <= count + (PTR_W + 1)'(1);
      else if (do_pop && !do_push) count <= count - (PTR_W + 1)'(1);
    end
  end

endmodule

[hdl/pta_back.sv]
`timescale 1ns / 1ps

module pta_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  pta_pkg::entry_t head,
  output logic            pop,
  pta_char_if.source      result
);

  logic                       out_valid;
  logic [pta_pkg::CHAR_W-1:0] out_char;
  logic                       out_last;
  logic                       glyph_done;
  logic                       load;
  logic                       glyph_pending;

  assign result.valid      = out_valid;
  assign result.character  = out_char;
  assign result.frame_last = out_last;

  // The output register takes a new request when it is empty or being taken.
  assign load          = !out_valid || result.ready;
  assign glyph_pending = head.glyph_valid && !glyph_done;
  assign pop           = load && head_valid && !(glyph_pending && head.newline_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      glyph_done <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        glyph_done <= glyph_pending && head.newline_valid;
      end
    end
  end

  // Glyph goes out first, then the newline of the same entry.
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      if (glyph_pending) begin
        out_char <= head.glyph;
        out_last <= 1'b0;
      end else begin
        out_char <= pta_pkg::NEWLINE_CODE;
        out_last <= head.newline_last;
      end
    end
  end

endmodule

[hdl/pixel_to_ascii_downscaler.sv]
`timescale 1ns / 1ps

// Channel  Role    Payload
// pixel    sink    red, green, blue (8 bits each), raster order
// result   source  character (7 bits), frame_last
// cfg      sink    index (3 bits), data (29 bits); always ready
//
// The front takes one pixel per cycle while the queue is not full and decides
// its results in that cycle. A pixel with a glyph and a newline gives two
// characters on the result side; the four-entry queue between front and back
// absorbs such bursts. A pixel's first result passes the queue and the output
// register of the back. Pixel ready drops only while the queue is full.
module pixel_to_ascii_downscaler #(
  parameter int MAX_IMAGE_DIM   = 4096,
  parameter int MAX_DISPLAY_DIM = 512,
  parameter int FRAC_BITS       = 16
) (
  input logic        clk,
  input logic        rst,
  pta_pixel_if.sink  pixel,
  pta_char_if.source result,
  pta_cfg_if.sink    cfg
);

  logic            queue_full;
  logic            push;
  pta_pkg::entry_t push_entry;
  logic            pop;
  logic            head_valid;
  pta_pkg::entry_t head;

  pta_front #(
    .MAX_IMAGE_DIM   (MAX_IMAGE_DIM),
    .MAX_DISPLAY_DIM (MAX_DISPLAY_DIM),
    .FRAC_BITS       (FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .cfg        (cfg),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  pta_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  pta_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .result     (result)
  );

endmodule

[test/ascii_frame_checker.sv]
`timescale 1ns / 1ps

import pta_pkg::*;

module ascii_frame_checker (
  input  logic clk,
  input  logic rst,
  pta_pixel_if pixel,
  pta_char_if  result,
  pta_cfg_if   cfg,
  output int   mismatches,
  output int   glyphs_pending
);

  localparam int FRAC        = 16;
  localparam int ACC_W       = 12 + FRAC;
  localparam int MAX_IMAGE   = 4096;
  localparam int MAX_DISPLAY = 512;
  localparam logic [STEP_W-1:0] UNIT    = STEP_W'(1) << FRAC;
  localparam logic [ACC_W-1:0]  ACC_MAX = '1;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } glyph_t;

  // Characters still owed by the block, oldest first.
  glyph_t glyph_queue[$];

  // Copy of the format registers.
  logic [IMG_CFG_W-1:0] img_w_reg;
  logic [IMG_CFG_W-1:0] img_h_reg;
  logic [DSP_CFG_W-1:0] dsp_w_reg;
  logic [DSP_CFG_W-1:0] dsp_h_reg;
  logic [STEP_W-1:0]    col_step_reg;
  logic [STEP_W-1:0]    row_step_reg;

  // Raster position, sampling accumulators and display progress.
  logic [11:0]      src_col;
  logic [11:0]      src_row;
  logic [ACC_W-1:0] col_acc;
  logic [ACC_W-1:0] row_acc;
  logic [9:0]       cols_out;
  logic [9:0]       rows_out;

  function automatic int clamp_dim(input int value, input int hi);
    if (value < 1) return 1;
    if (value > hi) return hi;
    return value;
  endfunction

  // Steps under 1.0 count as 1.0; the sum saturates at the accumulator top.
  function automatic logic [ACC_W-1:0] advance(input logic [ACC_W-1:0] acc,
                                               input logic [STEP_W-1:0] step);
    logic [STEP_W:0] total;
    total = {1'b0, ((step < UNIT) ? UNIT : step)};
    total = total + (STEP_W + 1)'(acc);
    if (total > (STEP_W + 1)'(ACC_MAX)) return ACC_MAX;
    return total[ACC_W-1:0];
  endfunction

  // Brightness bucket of the channel sum, dark to light.
  function automatic logic [CHAR_W-1:0] shade(input logic [9:0] sum);
    int  level;
    byte ch;
    level = int'(sum) / LEVEL_STEP;
    if (level > LEVEL_MAX) level = LEVEL_MAX;
    case (level)
      0:       ch = "@";
      1:       ch = "%";
      2:       ch = "#";
      3:       ch = "&";
      4:       ch = "+";
      5:       ch = "=";
      6:       ch = "^";
      7:       ch = "-";
      8:       ch = ":";
      9:       ch = ".";
      default: ch = " ";
    endcase
    return ch[CHAR_W-1:0];
  endfunction

  function automatic void push_glyph(input logic [CHAR_W-1:0] code, input logic last);
    glyph_t g;
    g.code = code;
    g.last = last;
    glyph_queue.push_back(g);
  endfunction

  function automatic void clear_raster();
    src_col  = '0;
    src_row  = '0;
    col_acc  = '0;
    row_acc  = '0;
    cols_out = '0;
    rows_out = '0;
  endfunction

  // Newline that ends a display row; it is the frame's last on the final row.
  task automatic close_row(input int dh);
    push_glyph(NEWLINE_CODE, (int'(rows_out) + 1) == dh);
    rows_out = rows_out + 10'd1;
    row_acc  = advance(row_acc, row_step_reg);
    col_acc  = '0;
    cols_out = '0;
  endtask

  // Works out the characters one raster pixel causes and moves the raster on.
  task automatic raster_to_glyphs(input logic [COLOR_W-1:0] r, g, b);
    int         iw, ih, dw, dh;
    logic       last_col, row_hit, closed;
    logic [9:0] sum;
    iw = clamp_dim(int'(img_w_reg), MAX_IMAGE);
    ih = clamp_dim(int'(img_h_reg), MAX_IMAGE);
    dw = clamp_dim(int'(dsp_w_reg), MAX_DISPLAY);
    dh = clamp_dim(int'(dsp_h_reg), MAX_DISPLAY);
    last_col = (int'(src_col) + 1) >= iw;
    row_hit  = (int'(rows_out) < dh) && (row_acc[ACC_W-1:FRAC] == src_row);
    closed   = 1'b0;

    if (row_hit && int'(cols_out) < dw && col_acc[ACC_W-1:FRAC] == src_col) begin
      sum = 10'(r) + 10'(g) + 10'(b);
      push_glyph(shade(sum), 1'b0);
      cols_out = cols_out + 10'd1;
      col_acc  = advance(col_acc, col_step_reg);
      if (int'(cols_out) >= dw) begin
        close_row(dh);
        closed = 1'b1;
      end
    end
    // A sampled source row that runs out early still closes its display row.
    if (row_hit && !closed && last_col) close_row(dh);

    if (last_col) begin
      src_col = '0;
      if ((int'(src_row) + 1) >= ih) clear_raster();
      else src_row = src_row + 12'd1;
    end else begin
      src_col = src_col + 12'd1;
    end
  endtask

  // Compare returned characters first, then take register writes and pixels.
  always @(posedge clk) begin : watch
    glyph_t want;
    if (rst) begin
      glyph_queue.delete();
      mismatches   = 0;
      img_w_reg    = IMAGE_WIDTH_RST;
      img_h_reg    = IMAGE_HEIGHT_RST;
      dsp_w_reg    = DISPLAY_WIDTH_RST;
      dsp_h_reg    = DISPLAY_HEIGHT_RST;
      col_step_reg = COLUMN_STEP_RST;
      row_step_reg = ROW_STEP_RST;
      clear_raster();
    end else begin
      if (result.valid && result.ready) begin
        if (glyph_queue.size() == 0) begin
          $error("unexpected result: character expected none, actual %0h",
                 result.character);
          mismatches++;
        end else begin
          want = glyph_queue.pop_front();
          if (result.character !== want.code) begin
            $error("character: expected %0h, actual %0h", want.code, result.character);
            mismatches++;
          end
          if (result.frame_last !== want.last) begin
            $error("frame_last: expected %0b, actual %0b", want.last, result.frame_last);
            mismatches++;
          end
        end
      end

      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_IMAGE_WIDTH:    img_w_reg    = cfg.data[IMG_CFG_W-1:0];
          CFG_IMAGE_HEIGHT:   img_h_reg    = cfg.data[IMG_CFG_W-1:0];
          CFG_DISPLAY_WIDTH:  dsp_w_reg    = cfg.data[DSP_CFG_W-1:0];
          CFG_DISPLAY_HEIGHT: dsp_h_reg    = cfg.data[DSP_CFG_W-1:0];
          CFG_COLUMN_STEP:    col_step_reg = cfg.data[STEP_W-1:0];
          CFG_ROW_STEP:       row_step_reg = cfg.data[STEP_W-1:0];
          default: ;
        endcase
      end

      if (pixel.valid && pixel.ready) raster_to_glyphs(pixel.red, pixel.green, pixel.blue);
    end
    glyphs_pending = glyph_queue.size();
  end

endmodule

[test/pixel_to_ascii_downscaler_tb.sv]
`timescale 1ns / 1ps

import pta_pkg::*;

module pixel_to_ascii_downscaler_tb;

  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_PIXELS = 680;
  localparam int CALM_AFTER    = 540;
  localparam int SETTLE_CYCLES = 8;
  localparam int STEP_UNIT     = 65536;
  localparam int STEP_TOP      = (1 << STEP_W) - 1;
  localparam int IMAGE_TOP     = (1 << IMG_CFG_W) - 1;
  localparam int DISPLAY_TOP   = (1 << DSP_CFG_W) - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP = '1;

  // Hand-picked pixels: channel extremes, brightness bucket edges, bit patterns.
  localparam logic [23:0] DIRECTED [24] = '{
    24'hFFFFFF, 24'h000000, 24'h808080, 24'h4C0000,
    24'h000000, 24'h191919, 24'h4C0000, 24'h009700,
    24'h000098, 24'hFFFFF9, 24'hFFFFFA, 24'hFFFFFF,
    24'h4C4C4C, 24'h666666, 24'h808080, 24'h999999,
    24'hB3B3B3, 24'hCCCCCC,
    24'h55AA55, 24'hAA55AA, 24'h0F0F0F, 24'hF0F0F0,
    24'h123456, 24'hFEDCBA
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sink_ready = 1'b0;
  int   mismatches;
  int   glyphs_pending;
  int   gap_rate;
  int   stall_rate;
  bit   calm;
  int   stall_left = 0;
  int   idle_cycles = 0;

  pta_pixel_if pixel_ch ();
  pta_char_if  result_ch ();
  pta_cfg_if   cfg_ch ();

  assign result_ch.ready = sink_ready;

  pixel_to_ascii_downscaler uut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pixel_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  ascii_frame_checker glyph_check (
    .clk            (clk),
    .rst            (rst),
    .pixel          (pixel_ch),
    .result         (result_ch),
    .cfg            (cfg_ch),
    .mismatches     (mismatches),
    .glyphs_pending (glyphs_pending)
  );

  always #4 clk = ~clk;

  // Character sink: random stall bursts of random length.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      sink_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && stall_rate != 0 && $urandom_range(1, stall_rate) == 1) begin
      sink_ready <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // Watchdog on cycles in which no channel moves a request.
  always @(posedge clk) begin
    if (rst || (pixel_ch.valid && pixel_ch.ready) || (result_ch.valid && result_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** pixel_to_ascii_downscaler: FAILED **");
      $finish;
    end
  end

  // Valid stays high after a request so back-to-back pixels follow without a gap.
  task automatic send_pixel(input logic [3*COLOR_W-1:0] rgb);
    if (!calm && gap_rate != 0 && $urandom_range(1, gap_rate) == 1) begin
      pixel_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    pixel_ch.valid <= 1'b1;
    {pixel_ch.red, pixel_ch.green, pixel_ch.blue} <= rgb;
    @(posedge clk);
    while (!pixel_ch.ready) @(posedge clk);
  endtask

  task automatic send_run(input int first, input int count);
    for (int i = first; i < first + count; i++) send_pixel(DIRECTED[i]);
  endtask

  function automatic logic [3*COLOR_W-1:0] random_pixel();
    logic [COLOR_W-1:0] level;
    level = COLOR_W'($urandom);
    if ($urandom_range(0, 3) == 0) return {level, level, level};
    return (3 * COLOR_W)'($urandom);
  endfunction

  // Stop sending and wait until every owed character has come back.
  task automatic drain_results();
    pixel_ch.valid <= 1'b0;
    @(posedge clk);
    while (glyphs_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Register value with random junk above its width half the time. For a
  // full-width register the shift and the mask both wrap to the plain value.
  function automatic logic [CFG_W-1:0] pad(input int value, input int width);
    logic [CFG_W-1:0] word;
    word = CFG_W'($urandom);
    if ($urandom_range(0, 1) == 0) word = '0;
    return (word << width) | (CFG_W'(value) & ((CFG_W'(1) << width) - 1'b1));
  endfunction

  task automatic program_format(input int iw, ih, dw, dh, cs, rs);
    write_reg(CFG_IMAGE_WIDTH, pad(iw, IMG_CFG_W));
    write_reg(CFG_IMAGE_HEIGHT, pad(ih, IMG_CFG_W));
    write_reg(CFG_DISPLAY_WIDTH, pad(dw, DSP_CFG_W));
    write_reg(CFG_DISPLAY_HEIGHT, pad(dh, DSP_CFG_W));
    write_reg(CFG_COLUMN_STEP, pad(cs, STEP_W));
    write_reg(CFG_ROW_STEP, pad(rs, STEP_W));
    // Unmapped indexes must leave the format alone.
    if ($urandom_range(0, 2) == 0) begin
      write_reg(CFG_IDX_TOP - CFG_IDX_W'($urandom_range(0, 1)), CFG_W'($urandom));
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // A one-pixel frame (zero or one clamps to one) ends wherever the raster
  // stood, so the next format starts from the top-left pixel.
  task automatic rewind_raster();
    drain_results();
    write_reg(CFG_IMAGE_WIDTH, pad($urandom_range(0, 1), IMG_CFG_W));
    write_reg(CFG_IMAGE_HEIGHT, pad($urandom_range(0, 1), IMG_CFG_W));
    cfg_ch.valid <= 1'b0;
    send_pixel(random_pixel());
    drain_results();
  endtask

  function automatic int extreme_of(input int clamp_top, input int reg_top);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 1;
      2:       return clamp_top;
      default: return reg_top;
    endcase
  endfunction

  initial begin
    int random_sent;
    int iw, ih, dw, dh, cs, rs, count;
    pixel_ch.valid <= 1'b0;
    pixel_ch.red   <= '0;
    pixel_ch.green <= '0;
    pixel_ch.blue  <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= '0;
    cfg_ch.data    <= '0;
    calm       = 1'b0;
    gap_rate   = 4;
    stall_rate = 4;
    random_sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Format after reset: every eighth column of every twentieth row is sampled.
    send_run(0, 4);
    // Every pixel sampled, step below one; the last newline ends the frame.
    rewind_raster();
    program_format(4, 2, 4, 2, 0, STEP_UNIT);
    send_run(4, 8);
    // Display wider and taller than the image: short rows, short frame.
    rewind_raster();
    program_format(3, 2, DISPLAY_TOP, DISPLAY_TOP, STEP_UNIT, STEP_UNIT);
    send_run(12, 6);
    // Display done after one row; later pixels are dropped. Row step saturates.
    rewind_raster();
    program_format(3, 2, 2, 1, 2 * STEP_UNIT, STEP_TOP);
    send_run(18, 6);

    // Random formats, mostly whole small frames, now and then register extremes.
    while (random_sent < RANDOM_PIXELS) begin
      calm = random_sent >= CALM_AFTER;
      gap_rate   = 2 * $urandom_range(0, 4);
      stall_rate = 2 * $urandom_range(0, 4);
      rewind_raster();
      if ($urandom_range(0, 7) == 0) begin
        iw = extreme_of(4096, IMAGE_TOP);
        ih = extreme_of(4096, IMAGE_TOP);
        dw = extreme_of(512, DISPLAY_TOP);
        dh = extreme_of(512, DISPLAY_TOP);
        cs = $urandom_range(0, 1) ? STEP_TOP : $urandom_range(0, STEP_UNIT);
        rs = $urandom_range(0, 1) ? STEP_TOP : $urandom_range(0, STEP_UNIT);
        count = $urandom_range(8, 48);
      end else begin
        iw = $urandom_range(1, 12);
        ih = $urandom_range(1, 8);
        dw = $urandom_range(1, iw + 1);
        dh = $urandom_range(1, ih + 1);
        cs = (iw * STEP_UNIT) / dw;
        rs = (ih * STEP_UNIT) / dh;
        if ($urandom_range(0, 2) == 0) cs = cs + $urandom_range(0, STEP_UNIT - 1) - STEP_UNIT / 2;
        if ($urandom_range(0, 2) == 0) rs = rs + $urandom_range(0, STEP_UNIT - 1) - STEP_UNIT / 2;
        if ($urandom_range(0, 9) == 0) cs = $urandom_range(0, STEP_UNIT - 1);
        if ($urandom_range(0, 9) == 0) rs = $urandom_range(0, STEP_UNIT - 1);
        count = $urandom_range(1, 3) * iw * ih;
      end
      program_format(iw, ih, dw, dh, cs, rs);
      for (int i = 0; i < count; i++) begin
        // Now and then hold the pixel stream until the output has caught up.
        if (!calm && $urandom_range(0, 63) == 0) drain_results();
        send_pixel(random_pixel());
      end
      random_sent += count;
    end

    drain_results();
    if (mismatches == 0 && glyphs_pending == 0) begin
      $display("** pixel_to_ascii_downscaler: PASSED **");
    end else begin
      $display("** pixel_to_ascii_downscaler: FAILED **");
    end
    $finish;
  end

endmodule

[pixel_to_ascii_downscaler.f]
hdl/pta_pkg.sv
hdl/pta_pixel_if.sv
hdl/pta_char_if.sv
hdl/pta_cfg_if.sv
hdl/pta_front.sv
hdl/pta_queue.sv
hdl/pta_back.sv
hdl/pixel_to_ascii_downscaler.sv
test/ascii_frame_checker.sv
test/pixel_to_ascii_downscaler_tb.sv
